// ===== src/bblc_pkg.sv =====
// Shared types, constants and codes of the byte budget LRU cache.
`timescale 1ns / 1ps
package bblc_pkg;

  localparam int unsigned DefEntries    = 8;
  localparam int unsigned DefKeyBits    = 16;
  localparam int unsigned LimitW        = 4;
  localparam int unsigned SizeW         = 32;
  localparam int unsigned StampW        = 48;
  localparam int unsigned BytesW        = 40;
  localparam int unsigned CntW          = 32;
  localparam int unsigned KeyInW        = 16;
  localparam logic [LimitW-1:0] DefEntryLimit = 4'd3;

  localparam logic [1:0] FuncLookup = 2'd0;
  localparam logic [1:0] FuncStore  = 2'd1;
  localparam logic [1:0] FuncTrim   = 2'd2;
  localparam logic [1:0] FuncClear  = 2'd3;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatDisabled = 2'd1;
  localparam logic [1:0] StatOversize = 2'd2;

  localparam logic CfgEntryLimit = 1'b0;
  localparam logic CfgByteLimit  = 1'b1;

  typedef struct packed {
    logic [1:0]        func;
    logic [KeyInW-1:0] key;
    logic [SizeW-1:0]  size_bytes;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [1:0]        status;
    logic [LimitW-1:0] evicted_now;
    logic [LimitW-1:0] entries_used;
    logic [BytesW-1:0] bytes_used;
    logic [CntW-1:0]   hit_total;
    logic [CntW-1:0]   miss_total;
    logic [CntW-1:0]   evict_total;
    logic [CntW-1:0]   skip_total;
  } rsp_t;

  // Command from the controller to every cell of the row.
  typedef struct packed {
    logic              clear;
    logic              touch;
    logic              shift;
    logic              append;
    logic [StampW-1:0] stamp;
    logic [SizeW-1:0]  size;
  } cell_cmd_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == '1) ? v : v + CntW'(1);
  endfunction

endpackage

// ===== src/bblc_cell.sv =====
// One slot of the entry row: key, size, stamp and the match and age chains.
`timescale 1ns / 1ps
module bblc_cell #(
  parameter int unsigned KeyBits = bblc_pkg::DefKeyBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bblc_pkg::cell_cmd_t          cmd_i,
  input  logic [KeyBits-1:0]           key_i,
  input  logic                         prev_valid_i,
  input  logic                         prev_found_i,
  input  logic                         prev_sel_i,
  input  logic [bblc_pkg::StampW-1:0]  prev_min_i,
  input  logic                         next_valid_i,
  input  logic [KeyBits-1:0]           next_key_i,
  input  logic [bblc_pkg::SizeW-1:0]   next_size_i,
  input  logic [bblc_pkg::StampW-1:0]  next_stamp_i,
  input  logic                         victim_i,
  output logic                         valid_o,
  output logic [KeyBits-1:0]           key_o,
  output logic [bblc_pkg::SizeW-1:0]   size_o,
  output logic [bblc_pkg::StampW-1:0]  stamp_o,
  output logic                         found_o,
  output logic                         match_o,
  output logic                         sel_o,
  output logic [bblc_pkg::StampW-1:0]  min_o,
  output logic                         is_min_o
);
  import bblc_pkg::*;

  logic               valid_q;
  logic [KeyBits-1:0] key_q;
  logic [SizeW-1:0]   size_q;
  logic [StampW-1:0]  stamp_q;
  logic               past_victim;

  assign match_o  = valid_q && !prev_found_i && (key_q == key_i);
  assign found_o  = prev_found_i || match_o;
  assign is_min_o = valid_q && (!prev_sel_i || stamp_q < prev_min_i);
  assign sel_o    = prev_sel_i || valid_q;
  assign min_o    = is_min_o ? stamp_q : prev_min_i;
  assign valid_o  = valid_q;
  assign key_o    = key_q;
  assign size_o   = size_q;
  assign stamp_o  = stamp_q;
  assign past_victim = victim_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.clear) begin
      valid_q <= 1'b0;
    end else if (cmd_i.shift && past_victim) begin
      valid_q <= next_valid_i;
    end else if (cmd_i.append && prev_valid_i && !valid_q) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.touch && match_o) begin
      stamp_q <= cmd_i.stamp;
    end else if (cmd_i.shift && past_victim) begin
      key_q   <= next_key_i;
      size_q  <= next_size_i;
      stamp_q <= next_stamp_i;
    end else if (cmd_i.append && prev_valid_i && !valid_q) begin
      key_q   <= key_i;
      size_q  <= cmd_i.size;
      stamp_q <= cmd_i.stamp;
    end
  end

endmodule

// ===== src/byte_budget_lru_cache.sv =====
// Top level of the byte budget LRU cache tag store.
//
// Requests enter on the in channel (in_valid_i, in_stall_o, in_data_i) and
// one response per request leaves on the out channel (out_valid_o,
// out_stall_i, out_data_o); a transfer happens when valid is high and stall
// is low. Configuration writes use cfg_valid_i and cfg_ready_o with a
// register index and data, and are made while the block is idle.
// The entries sit in a row of cells kept compacted from slot 0. A lookup
// resolves the whole row combinationally through the match chain. A store or
// trim evicts one entry per cycle: the age chain names the oldest slot, and
// that slot and every cell above it take their upper neighbour's contents.
// After the request transfer the block passes through the evict state, which
// it holds while evictions remain, and the finish state before it presents
// the response; an oversize store skips the finish state. The next request
// is taken after the response transfer, once the block is idle again.
// The response is held while out_stall_i is high and no new request is taken
// until it has been transferred.
// Reset empties the row, zeroes the counters and the use clock, and loads
// the entry limit with three and the byte limit with zero.
`timescale 1ns / 1ps
module byte_budget_lru_cache #(
  parameter int unsigned ENTRIES  = bblc_pkg::DefEntries,
  parameter int unsigned KEY_BITS = bblc_pkg::DefKeyBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bblc_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bblc_pkg::rsp_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_index_i,
  input  logic [31:0]     cfg_data_i
);
  import bblc_pkg::*;

  typedef enum logic [1:0] {SIdle, SEvict, SFinish, SOut} state_e;

  localparam int unsigned OccW = $clog2(ENTRIES + 1);

  state_e            state_q;
  req_t              req_q;
  rsp_t              rsp;
  logic [LimitW-1:0] entry_limit_q;
  logic [SizeW-1:0]  byte_limit_q;
  logic [BytesW-1:0] bytes_q;
  logic [StampW-1:0] clock_q;
  logic [CntW-1:0]   hit_cnt_q, miss_cnt_q, evict_cnt_q, skip_cnt_q;
  logic [LimitW-1:0] evicted_q;
  logic              hit_q;
  logic [1:0]        status_q;
  cell_cmd_t         cmd;

  logic [ENTRIES:0]          v_chain, f_chain, s_chain;
  logic [StampW-1:0]         m_chain [ENTRIES+1];
  logic [ENTRIES-1:0]        valid_w, match_w, is_min_w, victim_w;
  logic [KEY_BITS-1:0]       key_w   [ENTRIES];
  logic [SizeW-1:0]          size_w  [ENTRIES];
  logic [StampW-1:0]         stamp_w [ENTRIES];
  logic [KEY_BITS-1:0]       req_key;
  logic [OccW-1:0]           occ;
  logic [OccW-1:0]           lim;
  logic [SizeW-1:0]          vic_size;
  logic [ENTRIES-1:0]        last_min;
  logic                      need_evict;
  logic [BytesW:0]           sum_bytes;

  assign req_key = KEY_BITS'(req_q.key);
  assign v_chain[0] = 1'b1;
  assign f_chain[0] = 1'b0;
  assign s_chain[0] = 1'b0;
  assign m_chain[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_row
    logic              nv;
    logic [KEY_BITS-1:0] nk;
    logic [SizeW-1:0]  ns;
    logic [StampW-1:0] nt;
    if (g == ENTRIES - 1) begin : g_end
      assign nv = 1'b0;
      assign nk = '0;
      assign ns = '0;
      assign nt = '0;
    end else begin : g_mid
      assign nv = valid_w[g+1];
      assign nk = key_w[g+1];
      assign ns = size_w[g+1];
      assign nt = stamp_w[g+1];
    end
    bblc_cell #(.KeyBits(KEY_BITS)) u_cell (
      .clk_i, .rst_ni, .cmd_i(cmd), .key_i(req_key),
      .prev_valid_i(v_chain[g]), .prev_found_i(f_chain[g]),
      .prev_sel_i(s_chain[g]), .prev_min_i(m_chain[g]),
      .next_valid_i(nv), .next_key_i(nk), .next_size_i(ns), .next_stamp_i(nt),
      .victim_i(victim_w[g]), .valid_o(valid_w[g]), .key_o(key_w[g]),
      .size_o(size_w[g]), .stamp_o(stamp_w[g]), .found_o(f_chain[g+1]),
      .match_o(match_w[g]), .sel_o(s_chain[g+1]), .min_o(m_chain[g+1]),
      .is_min_o(is_min_w[g])
    );
    assign v_chain[g+1] = valid_w[g];
  end

  // The oldest slot is the last cell that lowered the running minimum;
  // every cell from it upwards shifts.
  always_comb begin
    last_min = '0;
    vic_size = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (is_min_w[i] && (last_min == '0)) begin
        last_min[i] = 1'b1;
        vic_size = size_w[i];
      end
    end
    victim_w[0] = last_min[0];
    for (int i = 1; i < ENTRIES; i++) begin
      victim_w[i] = victim_w[i-1] || last_min[i];
    end
  end

  always_comb begin
    occ = '0;
    for (int i = 0; i < ENTRIES; i++) occ = occ + OccW'(valid_w[i]);
  end

  assign lim = (32'(entry_limit_q) > ENTRIES) ? OccW'(ENTRIES) : OccW'(entry_limit_q);
  assign sum_bytes = {1'b0, bytes_q} + (BytesW + 1)'(req_q.size_bytes);

  always_comb begin
    need_evict = 1'b0;
    if (req_q.func == FuncStore) begin
      need_evict = (lim != '0) &&
        !((byte_limit_q != '0) && (req_q.size_bytes > byte_limit_q)) &&
        (occ != '0) && ((occ >= lim) ||
        ((byte_limit_q != '0) && (sum_bytes > (BytesW + 1)'(byte_limit_q))));
    end else if (req_q.func == FuncTrim) begin
      need_evict = (occ != '0) && (byte_limit_q != '0) &&
        (bytes_q > BytesW'(byte_limit_q));
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.stamp  = clock_q + StampW'(1);
    cmd.size   = req_q.size_bytes;
    if (state_q == SEvict) begin
      cmd.touch  = (req_q.func == FuncLookup) && (lim != '0);
      cmd.shift  = need_evict;
      cmd.clear  = (req_q.func == FuncClear);
    end else if (state_q == SFinish) begin
      cmd.append = (req_q.func == FuncStore) && (occ < lim);
    end
  end

  assign in_stall_o  = (state_q != SIdle);
  assign cfg_ready_o = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign out_data_o  = rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SIdle;
      entry_limit_q <= DefEntryLimit;
      byte_limit_q  <= '0;
      bytes_q       <= '0;
      clock_q       <= '0;
      hit_cnt_q     <= '0;
      miss_cnt_q    <= '0;
      evict_cnt_q   <= '0;
      skip_cnt_q    <= '0;
      evicted_q     <= '0;
      hit_q         <= 1'b0;
      status_q      <= StatOk;
    end else begin
      unique case (state_q)
        SIdle: begin
          if (cfg_valid_i) begin
            if (cfg_index_i == CfgEntryLimit) entry_limit_q <= cfg_data_i[LimitW-1:0];
            else                             byte_limit_q  <= cfg_data_i;
          end
          if (in_valid_i) begin
            evicted_q <= '0;
            hit_q     <= 1'b0;
            status_q  <= StatOk;
            state_q   <= SEvict;
          end
        end
        SEvict: begin
          if (req_q.func == FuncLookup) begin
            if (lim == '0) begin
              status_q <= StatDisabled;
            end else if (f_chain[ENTRIES]) begin
              hit_q     <= 1'b1;
              clock_q   <= cmd.stamp;
              hit_cnt_q <= sat_inc(hit_cnt_q);
            end else begin
              miss_cnt_q <= sat_inc(miss_cnt_q);
            end
            state_q <= SFinish;
          end else if (req_q.func == FuncStore && lim == '0) begin
            status_q <= StatDisabled;
            state_q  <= SFinish;
          end else if (req_q.func == FuncStore && byte_limit_q != '0 &&
                       req_q.size_bytes > byte_limit_q) begin
            status_q   <= StatOversize;
            skip_cnt_q <= sat_inc(skip_cnt_q);
            state_q    <= SOut;
          end else if (req_q.func == FuncClear) begin
            bytes_q <= '0;
            clock_q <= '0;
            state_q <= SFinish;
          end else if (need_evict) begin
            bytes_q     <= (BytesW'(vic_size) <= bytes_q) ? bytes_q - BytesW'(vic_size) : '0;
            evict_cnt_q <= sat_inc(evict_cnt_q);
            evicted_q   <= (evicted_q == '1) ? evicted_q : evicted_q + LimitW'(1);
          end else begin
            state_q <= SFinish;
          end
        end
        SFinish: begin
          if (cmd.append) begin
            clock_q <= cmd.stamp;
            bytes_q <= sum_bytes[BytesW] ? '1 : sum_bytes[BytesW-1:0];
          end
          state_q <= SOut;
        end
        SOut: begin
          if (!out_stall_i) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid_i) req_q <= in_data_i;
  end

  // The response is assembled from the registers that hold its fields.
  always_comb begin
    rsp = '0;
    rsp.hit          = hit_q;
    rsp.status       = status_q;
    rsp.evicted_now  = evicted_q;
    rsp.entries_used = LimitW'(occ);
    rsp.bytes_used   = bytes_q;
    rsp.hit_total    = hit_cnt_q;
    rsp.miss_total   = miss_cnt_q;
    rsp.evict_total  = evict_cnt_q;
    rsp.skip_total   = skip_cnt_q;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("response changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_w))
    else $error("more than one slot matched");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= OccW'(ENTRIES))
    else $error("occupancy beyond row");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.shift |-> $onehot(last_min))
    else $error("eviction without a single victim");

endmodule
